@@ hw/rtl/tiled_serpentine_led_index_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the serpentine LED index core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TILED_SERPENTINE_LED_INDEX_CORE_DEFINES_SVH
`define TILED_SERPENTINE_LED_INDEX_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSLI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tsli_pkg.sv @@
// ----------------------------------------------------------------------------
// tsli_pkg
// Types and constants for the tiled serpentine LED index core.
// ----------------------------------------------------------------------------
package tsli_pkg;

  localparam int COORD_W     = 8;
  localparam int SIZE_W      = 8;
  localparam int AREA_W      = 2 * SIZE_W;
  localparam int INDEX_W     = 18;
  localparam int COLOR_W     = 32;
  localparam int COUNT_W     = 3;
  localparam int LAYOUT_W    = 34;
  localparam int LAYOUT_REGS = 4;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_IDX_W   = 3;

  // register indexes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_TILE_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAYOUT_BASE = 3'd1;

  typedef enum logic [1:0] {
    ANCHOR_TOPLEFT  = 2'd0,
    ANCHOR_BTMRIGHT = 2'd1,
    ANCHOR_BTMLEFT  = 2'd2,
    ANCHOR_TOPRIGHT = 2'd3
  } anchor_t;

  typedef struct packed {
    anchor_t             anchor;
    logic [SIZE_W-1:0]   height;
    logic [SIZE_W-1:0]   width;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  x;
  } layout_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COLOR_W-1:0]  color;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  led_index;
    logic                hit;
    logic [COLOR_W-1:0]  color_out;
  } out_item_t;

  // per-module match result
  typedef struct packed {
    logic                hit;
    logic [AREA_W-1:0]   pos;
  } lane_res_t;

endpackage

@@ hw/rtl/tsli_lane.sv @@
// ----------------------------------------------------------------------------
// tsli_lane
// Containment test and serpentine position inside one module.
// ----------------------------------------------------------------------------
module tsli_lane (
  input  logic [tsli_pkg::COORD_W-1:0] px,
  input  logic [tsli_pkg::COORD_W-1:0] py,
  input  tsli_pkg::layout_t            layout,
  output tsli_pkg::lane_res_t          res
);

  logic [tsli_pkg::COORD_W:0]   x_end;
  logic [tsli_pkg::COORD_W:0]   y_end;
  logic                         in_x;
  logic                         in_y;
  logic [tsli_pkg::COORD_W-1:0] zx;
  logic [tsli_pkg::COORD_W-1:0] zy;
  logic [tsli_pkg::SIZE_W-1:0]  wm1;
  logic [tsli_pkg::SIZE_W-1:0]  hm1;
  logic [tsli_pkg::SIZE_W-1:0]  mul_a;
  logic [tsli_pkg::SIZE_W-1:0]  mul_b;
  logic [tsli_pkg::SIZE_W-1:0]  minor;
  logic [tsli_pkg::AREA_W-1:0]  major;

  // full-precision bounds, no wrap at the display edge
  assign x_end = {1'b0, layout.x} + {1'b0, layout.width};
  assign y_end = {1'b0, layout.y} + {1'b0, layout.height};
  assign in_x  = (px >= layout.x) && ({1'b0, px} < x_end);
  assign in_y  = (py >= layout.y) && ({1'b0, py} < y_end);

  assign zx  = px - layout.x;
  assign zy  = py - layout.y;
  assign wm1 = layout.width - 8'd1;
  assign hm1 = layout.height - 8'd1;

  // mul_a is the row (or column) counted from the anchor; its LSB sets direction
  always_comb begin
    case (layout.anchor)
      tsli_pkg::ANCHOR_TOPLEFT: begin
        mul_a = zy;
        mul_b = layout.width;
        minor = zy[0] ? (wm1 - zx) : zx;
      end
      tsli_pkg::ANCHOR_BTMRIGHT: begin
        mul_a = hm1 - zy;
        mul_b = layout.width;
        minor = mul_a[0] ? zx : (wm1 - zx);
      end
      tsli_pkg::ANCHOR_BTMLEFT: begin
        mul_a = zx;
        mul_b = layout.height;
        minor = zx[0] ? zy : (hm1 - zy);
      end
      tsli_pkg::ANCHOR_TOPRIGHT: begin
        mul_a = wm1 - zx;
        mul_b = layout.height;
        minor = mul_a[0] ? (hm1 - zy) : zy;
      end
      default: begin
        mul_a = zy;
        mul_b = layout.width;
        minor = zx;
      end
    endcase
  end

  assign major   = tsli_pkg::AREA_W'(mul_a) * tsli_pkg::AREA_W'(mul_b);
  assign res.hit = in_x && in_y;
  assign res.pos = major + {{(tsli_pkg::AREA_W-tsli_pkg::SIZE_W){1'b0}}, minor};

endmodule

@@ hw/rtl/tiled_serpentine_led_index_core.sv @@
// ----------------------------------------------------------------------------
// tiled_serpentine_led_index_core
// Maps pixel writes to LED chain positions on tiled zig-zag modules.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_data (pos_x, pos_y, color).
//   out channel : out_valid / out_stall / out_data (led_index, hit, color_out).
//   APB port    : tile count at 0x00, module layouts at 0x08..0x20.
//   One result per pixel. Each accepted pixel passes the input register and
//   then the result register, which raises out_valid for it.
//   Throughput is one pixel per cycle while out_stall is low; all modules are
//   tested in parallel, one 8x8 multiplier each.
//   Module areas are computed when a layout is written, so chain offsets
//   are ready for the first pixel after a write.
//   A miss gives hit=0 and led_index=0, color still passed through.
//   While out_stall holds a full result register, the input register still
//   takes one more pixel; once it is full as well, in_stall rises until
//   out_stall drops.
//   Reset (rst, synchronous) empties both registers and clears all
//   configuration to zero.
// ----------------------------------------------------------------------------
module tiled_serpentine_led_index_core #(
  parameter int MAX_MODULES = 4,
  parameter int COORD_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tsli_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tsli_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tsli_pkg::ADDR_W-1:0]  paddr,
  input  logic [tsli_pkg::DATA_W-1:0]  pwdata,
  output logic [tsli_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int NUM_LANES = (MAX_MODULES < tsli_pkg::LAYOUT_REGS) ?
                             MAX_MODULES : tsli_pkg::LAYOUT_REGS;
  localparam logic [tsli_pkg::COORD_W-1:0] COORD_MASK =
    (COORD_BITS >= tsli_pkg::COORD_W) ? {tsli_pkg::COORD_W{1'b1}} :
    tsli_pkg::COORD_W'((1 << COORD_BITS) - 1);

  // configuration
  logic [tsli_pkg::COUNT_W-1:0]   tile_count;
  tsli_pkg::layout_t              layout [NUM_LANES];
  logic [tsli_pkg::AREA_W-1:0]    area [NUM_LANES];
  logic [tsli_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  tsli_pkg::layout_t              wr_layout;

  // datapath
  logic                           in_full;
  tsli_pkg::in_item_t             in_q;
  tsli_pkg::out_item_t            out_next;
  logic                           advance;
  logic                           accept;
  logic [tsli_pkg::COORD_W-1:0]   px;
  logic [tsli_pkg::COORD_W-1:0]   py;
  tsli_pkg::lane_res_t            lane_res [NUM_LANES];
  logic [tsli_pkg::INDEX_W-1:0]   offset [NUM_LANES];

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_idx   = paddr[tsli_pkg::ADDR_W-1:tsli_pkg::ADDR_W-tsli_pkg::REG_IDX_W];
  assign wr_layout = tsli_pkg::layout_t'(pwdata[tsli_pkg::LAYOUT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count <= '0;
      for (int k = 0; k < NUM_LANES; k++) begin
        layout[k] <= '0;
        area[k]   <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx == tsli_pkg::REG_TILE_COUNT) begin
        tile_count <= pwdata[tsli_pkg::COUNT_W-1:0];
      end
      for (int k = 0; k < NUM_LANES; k++) begin
        if (reg_idx == tsli_pkg::REG_LAYOUT_BASE + tsli_pkg::REG_IDX_W'(k)) begin
          layout[k] <= wr_layout;
          area[k]   <= tsli_pkg::AREA_W'(wr_layout.width) *
                       tsli_pkg::AREA_W'(wr_layout.height);
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tsli_pkg::REG_TILE_COUNT) begin
      prdata = {{(tsli_pkg::DATA_W-tsli_pkg::COUNT_W){1'b0}}, tile_count};
    end
    for (int k = 0; k < NUM_LANES; k++) begin
      if (reg_idx == tsli_pkg::REG_LAYOUT_BASE + tsli_pkg::REG_IDX_W'(k)) begin
        prdata = {{(tsli_pkg::DATA_W-tsli_pkg::LAYOUT_W){1'b0}}, layout[k]};
      end
    end
  end

  // chain offset of each module: sum of the areas before it
  always_comb begin
    offset[0] = '0;
    for (int k = 1; k < NUM_LANES; k++) begin
      offset[k] = offset[k-1] +
                  {{(tsli_pkg::INDEX_W-tsli_pkg::AREA_W){1'b0}}, area[k-1]};
    end
  end

  // handshake
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
    if (advance && in_full) begin
      out_data <= out_next;
    end
  end

  assign px = in_q.pos_x & COORD_MASK;
  assign py = in_q.pos_y & COORD_MASK;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tsli_lane u_lane (
      .px     (px),
      .py     (py),
      .layout (layout[g]),
      .res    (lane_res[g])
    );
  end

  // first enabled module in chain order wins
  always_comb begin
    logic found;
    found              = 1'b0;
    out_next.led_index = '0;
    out_next.hit       = 1'b0;
    out_next.color_out = in_q.color;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (!found && lane_res[k].hit &&
          (tile_count > tsli_pkg::COUNT_W'(k))) begin
        found              = 1'b1;
        out_next.hit       = 1'b1;
        out_next.led_index = offset[k] +
          {{(tsli_pkg::INDEX_W-tsli_pkg::AREA_W){1'b0}}, lane_res[k].pos};
      end
    end
  end

endmodule

@@ hw/rtl/tsli_checker.sv @@
// ----------------------------------------------------------------------------
// tsli_checker
// Port-level checks for the serpentine LED index core, bound to the top.
// ----------------------------------------------------------------------------
`include "tiled_serpentine_led_index_core_defines.svh"

module tsli_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input tsli_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tsli_pkg::out_item_t out_data
);

  // a held result transaction keeps its payload
  `TSLI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "out transaction changed while stalled")

  // a stalled input transaction is held by the source
  `TSLI_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(in_data), "in transaction changed while stalled")

  // a miss never carries an index
  `TSLI_ASSERT_NOW(a_miss_zero, clk, rst, out_valid && !out_data.hit, out_data.led_index == '0, "miss with nonzero led_index")

  // input only backs up when the output is stalled
  `TSLI_ASSERT_NOW(a_stall_cause, clk, rst, !out_stall, !in_stall, "in_stall without out_stall")

  // nothing comes out right after reset
  `TSLI_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid, "out_valid right after reset")

endmodule

bind tiled_serpentine_led_index_core tsli_checker u_tsli_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/tsli_led_checker.sv @@
// ----------------------------------------------------------------------------
// tsli_led_checker
// Watches the register port and both pixel channels of the LED index core.
// Keeps its own copy of the chain setup, works out the LED position of
// each accepted pixel and compares every returned transaction, in order.
// ----------------------------------------------------------------------------
module tsli_led_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  tsli_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  tsli_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [tsli_pkg::ADDR_W-1:0]  paddr,
  input  logic [tsli_pkg::DATA_W-1:0]  pwdata,
  output int                           mismatches,
  output int                           outstanding
);

  logic [tsli_pkg::COUNT_W-1:0] chain_len;
  tsli_pkg::layout_t            tile_cfg [tsli_pkg::LAYOUT_REGS];
  tsli_pkg::out_item_t          expected_leds [$];
  int                           err_count = 0;
  int                           waiting   = 0;

  assign mismatches  = err_count;
  assign outstanding = waiting;

  // LED position along the chain for one pixel, given the current setup
  function automatic tsli_pkg::out_item_t map_pixel(tsli_pkg::in_item_t pix);
    tsli_pkg::out_item_t res;
    int        limit, base, px, py, mx, my, w, h;
    int        zx, zy, rev, major, minor, k;
    bit        found;
    res.led_index = '0;
    res.hit       = 1'b0;
    res.color_out = pix.color;
    limit = (chain_len > tsli_pkg::LAYOUT_REGS) ? tsli_pkg::LAYOUT_REGS : chain_len;
    base  = 0;
    found = 1'b0;
    px    = pix.pos_x;
    py    = pix.pos_y;
    for (k = 0; k < limit; k++) begin
      if (!found) begin
        mx = tile_cfg[k].x;
        my = tile_cfg[k].y;
        w  = tile_cfg[k].width;
        h  = tile_cfg[k].height;
        // bounds at full precision: a tile may hang past the display edge
        if (px >= mx && px < mx + w && py >= my && py < my + h) begin
          zx    = px - mx;
          zy    = py - my;
          major = 0;
          minor = 0;
          case (tile_cfg[k].anchor)
            tsli_pkg::ANCHOR_TOPLEFT: begin
              major = zy * w;
              minor = (zy % 2 != 0) ? (w - 1 - zx) : zx;
            end
            tsli_pkg::ANCHOR_BTMRIGHT: begin
              rev   = h - 1 - zy;
              major = rev * w;
              minor = (rev % 2 != 0) ? zx : (w - 1 - zx);
            end
            tsli_pkg::ANCHOR_BTMLEFT: begin
              major = zx * h;
              minor = (zx % 2 != 0) ? zy : (h - 1 - zy);
            end
            tsli_pkg::ANCHOR_TOPRIGHT: begin
              rev   = w - 1 - zx;
              major = rev * h;
              minor = (rev % 2 != 0) ? (h - 1 - zy) : zy;
            end
            default: begin
              major = 0;
              minor = 0;
            end
          endcase
          res.led_index = tsli_pkg::INDEX_W'(base + major + minor);
          res.hit       = 1'b1;
          found         = 1'b1;
        end else begin
          base += w * h;
        end
      end
    end
    return res;
  endfunction

  task automatic flag_field(string what, logic [63:0] want, logic [63:0] got);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    tsli_pkg::out_item_t want;
    int        idx;
    if (rst) begin
      expected_leds.delete();
      chain_len = '0;
      for (int k = 0; k < tsli_pkg::LAYOUT_REGS; k++) tile_cfg[k] = '0;
    end else begin
      if (in_valid && !in_stall) expected_leds.push_back(map_pixel(in_data));
      if (out_valid && !out_stall) begin
        if (expected_leds.size() == 0) begin
          flag_field("unexpected transaction, led_index", 64'd0,
                     64'(out_data.led_index));
        end else begin
          want = expected_leds.pop_front();
          if (out_data.led_index !== want.led_index)
            flag_field("led_index", 64'(want.led_index), 64'(out_data.led_index));
          if (out_data.hit !== want.hit)
            flag_field("hit", 64'(want.hit), 64'(out_data.hit));
          if (out_data.color_out !== want.color_out)
            flag_field("color_out", 64'(want.color_out), 64'(out_data.color_out));
        end
      end
      // writes past the last layout register are dropped
      if (psel && penable && pwrite && pready) begin
        idx = paddr[tsli_pkg::ADDR_W-1:3];
        if (idx == tsli_pkg::REG_TILE_COUNT)
          chain_len = pwdata[tsli_pkg::COUNT_W-1:0];
        else if (idx >= tsli_pkg::REG_LAYOUT_BASE &&
                 idx < tsli_pkg::REG_LAYOUT_BASE + tsli_pkg::LAYOUT_REGS)
          tile_cfg[idx - tsli_pkg::REG_LAYOUT_BASE] = pwdata[tsli_pkg::LAYOUT_W-1:0];
      end
    end
    waiting <= expected_leds.size();
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Pixel stream test for the tiled serpentine LED index core. Sets up the
// tile chain over the register port, sends directed corner and edge pixels
// and then aimed random pixels under several random chain setups, with
// random idles on both channels; the checker judges every transaction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [tsli_pkg::REG_IDX_W-1:0] SPARE_REG_FIRST =
    tsli_pkg::REG_IDX_W'(tsli_pkg::REG_LAYOUT_BASE + tsli_pkg::LAYOUT_REGS);

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  tsli_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  tsli_pkg::out_item_t           out_data;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [tsli_pkg::ADDR_W-1:0]   paddr     = '0;
  logic [tsli_pkg::DATA_W-1:0]   pwdata    = '0;
  logic [tsli_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  bit                            steady    = 1'b0;
  int                            mismatches, outstanding;
  tsli_pkg::layout_t             tiles [tsli_pkg::LAYOUT_REGS];

  tiled_serpentine_led_index_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tsli_led_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 6);
  end

  function automatic tsli_pkg::layout_t make_tile(logic [7:0] x, logic [7:0] y,
                                                  logic [7:0] w, logic [7:0] h,
                                                  tsli_pkg::anchor_t corner);
    tsli_pkg::layout_t t;
    t.x      = x;
    t.y      = y;
    t.width  = w;
    t.height = h;
    t.anchor = corner;
    return t;
  endfunction

  function automatic logic [7:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 24));
    endcase
  endfunction

  // sometimes fill the unused upper bits of a write with noise
  function automatic logic [tsli_pkg::DATA_W-1:0] with_junk(
      logic [tsli_pkg::DATA_W-1:0] val, int keep);
    logic [tsli_pkg::DATA_W-1:0] noise;
    noise = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return val | (noise << keep);
    return val;
  endfunction

  // setup cycle, access cycle, then the bus goes idle
  task automatic write_reg(logic [tsli_pkg::REG_IDX_W-1:0] idx,
                           logic [tsli_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_tiles(int cnt);
    write_reg(tsli_pkg::REG_TILE_COUNT,
              with_junk(tsli_pkg::DATA_W'(cnt), tsli_pkg::COUNT_W));
    for (int k = 0; k < tsli_pkg::LAYOUT_REGS; k++)
      write_reg(tsli_pkg::REG_IDX_W'(tsli_pkg::REG_LAYOUT_BASE + k),
                with_junk(tsli_pkg::DATA_W'(tiles[k]), tsli_pkg::LAYOUT_W));
  endtask

  task automatic push_pixel(logic [7:0] x, logic [7:0] y, logic [31:0] c);
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {x, y, c};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // block must be idle before the chain setup changes
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  // mostly inside a tile, some just past its right edge, some anywhere
  task automatic aim_pixel(output logic [7:0] x, output logic [7:0] y);
    tsli_pkg::layout_t t;
    t = tiles[$urandom_range(0, tsli_pkg::LAYOUT_REGS - 1)];
    if ($urandom_range(0, 4) == 0 || t.width == 0 || t.height == 0) begin
      x = 8'($urandom);
      y = 8'($urandom);
    end else begin
      x = t.x + 8'($urandom_range(0, t.width - 1));
      y = t.y + 8'($urandom_range(0, t.height - 1));
      if ($urandom_range(0, 9) == 0) x = t.x + t.width;
    end
  endtask

  initial begin
    logic [7:0] px, py;
    int         side, row_y, cnt;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // setup straight out of reset: no tiles, everything misses
    push_pixel(8'd0, 8'd0, 32'h0);
    push_pixel(8'd255, 8'd255, 32'hFFFF_FFFF);
    settle();

    // one small tile per anchor corner, the last one hanging off the edge
    tiles[0] = make_tile(8'd10, 8'd10, 8'd4, 8'd3, tsli_pkg::ANCHOR_TOPLEFT);
    tiles[1] = make_tile(8'd20, 8'd10, 8'd4, 8'd3, tsli_pkg::ANCHOR_BTMRIGHT);
    tiles[2] = make_tile(8'd30, 8'd10, 8'd3, 8'd4, tsli_pkg::ANCHOR_BTMLEFT);
    tiles[3] = make_tile(8'd250, 8'd250, 8'd10, 8'd10, tsli_pkg::ANCHOR_TOPRIGHT);
    apply_tiles(4);
    for (int j = 0; j < 3; j++)
      write_reg(tsli_pkg::REG_IDX_W'(SPARE_REG_FIRST + j), {$urandom, $urandom});
    push_pixel(8'd10, 8'd10, $urandom);
    push_pixel(8'd13, 8'd10, $urandom);
    push_pixel(8'd10, 8'd11, $urandom);
    push_pixel(8'd13, 8'd12, $urandom);
    push_pixel(8'd20, 8'd10, $urandom);
    push_pixel(8'd23, 8'd12, $urandom);
    push_pixel(8'd20, 8'd11, $urandom);
    push_pixel(8'd30, 8'd10, $urandom);
    push_pixel(8'd32, 8'd13, $urandom);
    push_pixel(8'd31, 8'd10, $urandom);
    push_pixel(8'd250, 8'd250, $urandom);
    push_pixel(8'd255, 8'd255, $urandom);
    push_pixel(8'd251, 8'd253, $urandom);
    push_pixel(8'd0, 8'd0, $urandom);
    settle();

    // count above four, full-size tiles, an empty tile, largest offsets
    tiles[0] = make_tile(8'd255, 8'd255, 8'd255, 8'd255, tsli_pkg::ANCHOR_TOPRIGHT);
    tiles[1] = make_tile(8'd255, 8'd255, 8'd255, 8'd255, tsli_pkg::ANCHOR_TOPRIGHT);
    tiles[2] = make_tile(8'd0, 8'd0, 8'd0, 8'd255, tsli_pkg::ANCHOR_BTMLEFT);
    tiles[3] = make_tile(8'd0, 8'd0, 8'd255, 8'd255, tsli_pkg::ANCHOR_TOPLEFT);
    apply_tiles(7);
    push_pixel(8'd255, 8'd255, 32'hFFFF_FFFF);
    push_pixel(8'd0, 8'd0, 32'h0);
    push_pixel(8'd254, 8'd254, $urandom);
    push_pixel(8'd0, 8'd254, $urandom);
    push_pixel(8'd254, 8'd0, $urandom);
    push_pixel(8'd128, 8'd77, $urandom);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      steady <= (ph == 3);
      if ($urandom_range(0, 2) == 0) begin
        // tiles side by side in one row, as a real panel is built
        side  = $urandom_range(1, 32);
        row_y = $urandom_range(0, 200);
        for (int k = 0; k < tsli_pkg::LAYOUT_REGS; k++)
          tiles[k] = make_tile(8'(k * side), 8'(row_y), 8'(side), 8'(side),
                               tsli_pkg::anchor_t'($urandom_range(0, 3)));
      end else begin
        for (int k = 0; k < tsli_pkg::LAYOUT_REGS; k++)
          tiles[k] = make_tile(8'($urandom), 8'($urandom), pick_span(), pick_span(),
                               tsli_pkg::anchor_t'($urandom_range(0, 3)));
      end
      cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      apply_tiles(cnt);
      repeat (100) begin
        aim_pixel(px, py);
        push_pixel(px, py, $urandom);
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tsli_pkg.sv
hw/rtl/tsli_lane.sv
hw/rtl/tiled_serpentine_led_index_core.sv
hw/rtl/tsli_checker.sv
verif/tsli_led_checker.sv
verif/tb_top.sv
